### hdl/rbst_pkg.sv
package rbst_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SUB_LAT   = 3;
  // Quotient bits: hidden bit, 23 fraction bits, guard and round.
  localparam int unsigned Q_BITS    = 26;
  localparam int unsigned DIV_BITS  = 2;
  localparam int unsigned DIV_STEPS = Q_BITS / DIV_BITS;
  localparam int unsigned DIV_LAT   = DIV_STEPS + 2;
  localparam int unsigned CMP_LAT   = 3;
  localparam int unsigned PIPE_LAT  = SUB_LAT + DIV_LAT + CMP_LAT;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_A_X = 3'd0,
    CFG_A_Y = 3'd1,
    CFG_A_Z = 3'd2,
    CFG_B_X = 3'd3,
    CFG_B_Y = 3'd4,
    CFG_B_Z = 3'd5
  } cfg_reg_e;

  function automatic logic is_nan(logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(logic [31:0] v);
    return (v[30:0] == 31'h7F80_0000);
  endfunction

  function automatic logic is_zero(logic [31:0] v);
    return (v[30:0] == 31'd0);
  endfunction

  // Ordered greater-than; false whenever a NaN is involved, and zeros compare equal.
  function automatic logic fgt(logic [31:0] a, logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    ka = a[31] ? ~a : {1'b1, a[30:0]};
    kb = b[31] ? ~b : {1'b1, b[30:0]};
    return !is_nan(a) && !is_nan(b) && !(is_zero(a) && is_zero(b)) && (ka > kb);
  endfunction

  function automatic logic [5:0] lzc32(logic [31:0] v);
    logic [5:0] n;
    logic       found;
    n     = 6'd0;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found) begin
        if (v[i]) found = 1'b1;
        else n = n + 6'd1;
      end
    end
    return n;
  endfunction

  // s[26:3] is the significand, s[2] guard, s[1] round, s[0] sticky.
  // exp is at least 1; a significand without its top bit is subnormal.
  function automatic logic [31:0] round_pack(logic sign, logic signed [11:0] exp,
                                             logic [26:0] s);
    logic              up;
    logic [24:0]       m;
    logic signed [11:0] e;
    up = s[2] & (s[1] | s[0] | s[3]);
    m  = {1'b0, s[26:3]} + {24'd0, up};
    e  = exp;
    if (m[24]) begin
      e = e + 12'sd1;
      m = m >> 1;
    end
    if (e >= 12'sd255) return {sign, 8'hFF, 23'd0};
    else if (!m[23]) return {sign, 8'd0, m[22:0]};
    else return {sign, e[7:0], m[22:0]};
  endfunction

endpackage

### hdl/rbst_ray_if.sv
interface rbst_ray_if;
  logic        valid;
  logic        ready;
  logic [31:0] origin_x;
  logic [31:0] origin_y;
  logic [31:0] origin_z;
  logic [31:0] dir_x;
  logic [31:0] dir_y;
  logic [31:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

### hdl/rbst_hit_if.sv
interface rbst_hit_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

### hdl/ray_box_slab_test_top.sv
// Channel   Dir  Payload                                   Transfer when
// ray_i     in   origin_x/y/z, dir_x/y/z (32-bit floats)   valid & ready
// hit_o     out  hit (1 bit)                               valid & ready
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i           cfg_we_i high
//
// One ray per cycle while hit_o is not stalled; each ray passes through the float
// subtractors, the divider (2 quotient bits per stage) and the compare stages.
// All stages advance together; the stall comes from the output register.
// Reset clears the valid bits and the box corners; payload is not reset.
module ray_box_slab_test_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rbst_ray_if.sink                       ray_i,
  rbst_hit_if.source                     hit_o,
  input  logic                           cfg_we_i,
  input  logic [rbst_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i
);
  import rbst_pkg::*;

  logic [31:0] corner_a_q [3];
  logic [31:0] corner_b_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        corner_a_q[i] <= 32'd0;
        corner_b_q[i] <= 32'd0;
      end
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_A_X: corner_a_q[0] <= cfg_data_i;
        CFG_A_Y: corner_a_q[1] <= cfg_data_i;
        CFG_A_Z: corner_a_q[2] <= cfg_data_i;
        CFG_B_X: corner_b_q[0] <= cfg_data_i;
        CFG_B_Y: corner_b_q[1] <= cfg_data_i;
        CFG_B_Z: corner_b_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic                adv, accept;
  logic [PIPE_LAT-1:0] vld_d, vld_q;

  assign adv    = !vld_q[PIPE_LAT-1] || hit_o.ready;
  assign accept = ray_i.valid && adv;
  assign vld_d  = {vld_q[PIPE_LAT-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= vld_d;
  end

  assign ray_i.ready = adv;
  assign hit_o.valid = vld_q[PIPE_LAT-1];

  logic [31:0] org [3];
  logic [31:0] dir [3];

  assign org[0] = ray_i.origin_x;
  assign org[1] = ray_i.origin_y;
  assign org[2] = ray_i.origin_z;
  assign dir[0] = ray_i.dir_x;
  assign dir[1] = ray_i.dir_y;
  assign dir[2] = ray_i.dir_z;

  // Directions wait for the numerators.
  logic [31:0] dir_q [SUB_LAT][3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        dir_q[0][a] <= dir[a];
        for (int s = 1; s < SUB_LAT; s++) dir_q[s][a] <= dir_q[s-1][a];
      end
    end
  end

  logic [31:0] na [3];
  logic [31:0] nb [3];
  logic [31:0] ta [3];
  logic [31:0] tb [3];

  for (genvar a = 0; a < 3; a++) begin : g_lane
    rbst_fsub u_sub_a (
      .clk_i (clk_i), .en_i (adv), .a_i (corner_a_q[a]), .b_i (org[a]), .res_o (na[a])
    );
    rbst_fsub u_sub_b (
      .clk_i (clk_i), .en_i (adv), .a_i (corner_b_q[a]), .b_i (org[a]), .res_o (nb[a])
    );
    rbst_fdiv u_div_a (
      .clk_i (clk_i), .en_i (adv), .n_i (na[a]), .d_i (dir_q[SUB_LAT-1][a]), .res_o (ta[a])
    );
    rbst_fdiv u_div_b (
      .clk_i (clk_i), .en_i (adv), .n_i (nb[a]), .d_i (dir_q[SUB_LAT-1][a]), .res_o (tb[a])
    );
  end

  rbst_cmp u_cmp (
    .clk_i (clk_i),
    .en_i  (adv),
    .ta_i  (ta),
    .tb_i  (tb),
    .hit_o (hit_o.hit)
  );

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> vld_q[0])
    else $error("accepted ray did not enter the pipeline");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_bubble_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && !vld_q[0]) |=> !vld_q[1])
    else $error("bubble turned into an item");

endmodule

### hdl/rbst_fsub.sv
module rbst_fsub (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] res_o
);
  import rbst_pkg::*;

  // Stage 1: specials, operand swap and alignment.
  logic [31:0] nb, x, y;
  logic        swap;
  logic [7:0]  ex, ey, d;
  logic [4:0]  dd;
  logic [23:0] mx, my;
  logic [53:0] wide;
  logic [26:0] ya;
  logic        nan1, inf1, isg1;

  always_comb begin
    nb   = {~b_i[31], b_i[30:0]};
    swap = b_i[30:0] > a_i[30:0];
    x    = swap ? nb : a_i;
    y    = swap ? a_i : nb;
    ex   = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey   = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    mx   = {x[30:23] != 8'd0, x[22:0]};
    my   = {y[30:23] != 8'd0, y[22:0]};
    d    = ex - ey;
    dd   = (d > 8'd26) ? 5'd27 : d[4:0];
    wide = {my, 3'b000, 27'd0} >> dd;
    ya   = {wide[53:28], wide[27] | (|wide[26:0])};
    nan1 = is_nan(a_i) || is_nan(b_i) ||
           (is_inf(a_i) && is_inf(b_i) && (a_i[31] == b_i[31]));
    inf1 = is_inf(a_i) || is_inf(b_i);
    isg1 = is_inf(a_i) ? a_i[31] : nb[31];
  end

  logic        s1_sign_q, s1_sub_q, s1_nan_q, s1_inf_q, s1_isg_q;
  logic [7:0]  s1_ex_q;
  logic [26:0] s1_mx_q, s1_ya_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sign_q <= x[31];
      s1_sub_q  <= x[31] ^ y[31];
      s1_nan_q  <= nan1;
      s1_inf_q  <= inf1;
      s1_isg_q  <= isg1;
      s1_ex_q   <= ex;
      s1_mx_q   <= {mx, 3'b000};
      s1_ya_q   <= ya;
    end
  end

  // Stage 2: add and normalize.
  logic [27:0]        sum;
  logic [4:0]         lz;
  logic [7:0]         lim;
  logic [4:0]         sh;
  logic [26:0]        s2;
  logic signed [11:0] e2;

  always_comb begin
    sum = s1_sub_q ? ({1'b0, s1_mx_q} - {1'b0, s1_ya_q})
                   : ({1'b0, s1_mx_q} + {1'b0, s1_ya_q});
    lz  = 5'(lzc32({sum[26:0], 5'h1F}));
    lim = s1_ex_q - 8'd1;
    sh  = ({3'd0, lz} > lim) ? lim[4:0] : lz;
    if (sum[27]) begin
      s2 = {sum[27:2], sum[1] | sum[0]};
      e2 = $signed({4'd0, s1_ex_q}) + 12'sd1;
    end else begin
      s2 = sum[26:0] << sh;
      e2 = $signed({4'd0, s1_ex_q}) - $signed({7'd0, sh});
    end
  end

  logic               s2_sign_q, s2_nan_q, s2_inf_q, s2_isg_q, s2_zero_q;
  logic [26:0]        s2_s_q;
  logic signed [11:0] s2_e_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_sign_q <= s1_sign_q;
      s2_nan_q  <= s1_nan_q;
      s2_inf_q  <= s1_inf_q;
      s2_isg_q  <= s1_isg_q;
      s2_zero_q <= (sum == 28'd0);
      s2_s_q    <= s2;
      s2_e_q    <= e2;
    end
  end

  // Stage 3: round and pack.
  logic [31:0] res_d, res_q;

  always_comb begin
    if (s2_nan_q) res_d = QNAN_BITS;
    else if (s2_inf_q) res_d = {s2_isg_q, 8'hFF, 23'd0};
    else if (s2_zero_q) res_d = 32'd0;
    else res_d = round_pack(s2_sign_q, s2_e_q, s2_s_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

### hdl/rbst_fdiv.sv
module rbst_fdiv (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] n_i,
  input  logic [31:0] d_i,
  output logic [31:0] res_o
);
  import rbst_pkg::*;

  // Prep stage: specials, normalize subnormal operands, exponent.
  logic [23:0]        mn, md, mnn, mdn;
  logic [4:0]         lzn, lzd;
  logic signed [11:0] en_e, ed_e, ex0;
  logic               lt, nan0, inf0, zro0;
  logic [24:0]        rem0;

  always_comb begin
    mn   = {n_i[30:23] != 8'd0, n_i[22:0]};
    md   = {d_i[30:23] != 8'd0, d_i[22:0]};
    lzn  = 5'(lzc32({mn, 8'hFF}));
    lzd  = 5'(lzc32({md, 8'hFF}));
    mnn  = mn << lzn;
    mdn  = md << lzd;
    en_e = $signed({4'd0, (n_i[30:23] == 8'd0) ? 8'd1 : n_i[30:23]}) -
           $signed({7'd0, lzn});
    ed_e = $signed({4'd0, (d_i[30:23] == 8'd0) ? 8'd1 : d_i[30:23]}) -
           $signed({7'd0, lzd});
    lt   = mnn < mdn;
    rem0 = lt ? {mnn, 1'b0} : {1'b0, mnn};
    ex0  = en_e - ed_e + 12'sd127 - $signed({11'd0, lt});
    nan0 = is_nan(n_i) || is_nan(d_i) || (is_zero(n_i) && is_zero(d_i)) ||
           (is_inf(n_i) && is_inf(d_i));
    inf0 = !nan0 && (is_zero(d_i) || is_inf(n_i));
    zro0 = !nan0 && !inf0 && (is_zero(n_i) || is_inf(d_i));
  end

  logic [24:0]        rem_q  [DIV_STEPS+1];
  logic [25:0]        quo_q  [DIV_STEPS+1];
  logic [23:0]        md_q   [DIV_STEPS+1];
  logic signed [11:0] ex_q   [DIV_STEPS+1];
  logic               sign_q [DIV_STEPS+1];
  logic               nan_q  [DIV_STEPS+1];
  logic               inf_q  [DIV_STEPS+1];
  logic               zro_q  [DIV_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rem0;
      quo_q[0]  <= '0;
      md_q[0]   <= mdn;
      ex_q[0]   <= ex0;
      sign_q[0] <= n_i[31] ^ d_i[31];
      nan_q[0]  <= nan0;
      inf_q[0]  <= inf0;
      zro_q[0]  <= zro0;
    end
  end

  // Restoring division, a fixed number of quotient bits per stage.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [24:0] r_c;
    logic [25:0] q_c;

    always_comb begin
      r_c = rem_q[k];
      q_c = quo_q[k];
      for (int j = 0; j < DIV_BITS; j++) begin
        if (r_c >= {1'b0, md_q[k]}) begin
          r_c = r_c - {1'b0, md_q[k]};
          q_c = {q_c[24:0], 1'b1};
        end else begin
          q_c = {q_c[24:0], 1'b0};
        end
        r_c = {r_c[23:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= r_c;
        quo_q[k+1]  <= q_c;
        md_q[k+1]   <= md_q[k];
        ex_q[k+1]   <= ex_q[k];
        sign_q[k+1] <= sign_q[k];
        nan_q[k+1]  <= nan_q[k];
        inf_q[k+1]  <= inf_q[k];
        zro_q[k+1]  <= zro_q[k];
      end
    end
  end

  // Final stage: shift into the subnormal range if needed, round, pack.
  logic [26:0]        s27, sf;
  logic signed [11:0] shv, ef;
  logic [4:0]         shc;
  logic [53:0]        wide;
  logic [31:0]        res_d, res_q;

  always_comb begin
    s27  = {quo_q[DIV_STEPS], rem_q[DIV_STEPS] != 25'd0};
    shv  = 12'sd1 - ex_q[DIV_STEPS];
    shc  = (shv > 12'sd27) ? 5'd27 : shv[4:0];
    wide = {s27, 27'd0} >> shc;
    if (ex_q[DIV_STEPS] < 12'sd1) begin
      sf = {wide[53:28], wide[27] | (|wide[26:0])};
      ef = 12'sd1;
    end else begin
      sf = s27;
      ef = ex_q[DIV_STEPS];
    end
    if (nan_q[DIV_STEPS]) res_d = QNAN_BITS;
    else if (inf_q[DIV_STEPS]) res_d = {sign_q[DIV_STEPS], 8'hFF, 23'd0};
    else if (zro_q[DIV_STEPS]) res_d = {sign_q[DIV_STEPS], 31'd0};
    else res_d = round_pack(sign_q[DIV_STEPS], ef, sf);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

### hdl/rbst_cmp.sv
module rbst_cmp (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] ta_i [3],
  input  logic [31:0] tb_i [3],
  output logic        hit_o
);
  import rbst_pkg::*;

  // Stage 1: order each axis interval.
  logic [31:0] lo_q [3];
  logic [31:0] hi_q [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic sw;
    assign sw = fgt(ta_i[a], tb_i[a]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lo_q[a] <= sw ? tb_i[a] : ta_i[a];
        hi_q[a] <= sw ? ta_i[a] : tb_i[a];
      end
    end
  end

  // Stage 2: test x against y and merge.
  logic        rej1_q;
  logic [31:0] tmin_q, tmax_q, zlo_q, zhi_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rej1_q <= fgt(lo_q[0], hi_q[1]) || fgt(lo_q[1], hi_q[0]);
      tmin_q <= fgt(lo_q[1], lo_q[0]) ? lo_q[1] : lo_q[0];
      tmax_q <= fgt(hi_q[0], hi_q[1]) ? hi_q[1] : hi_q[0];
      zlo_q  <= lo_q[2];
      zhi_q  <= hi_q[2];
    end
  end

  // Stage 3: test the merged interval against z.
  logic hit_q;

  always_ff @(posedge clk_i) begin
    if (en_i) hit_q <= !rej1_q && !fgt(tmin_q, zhi_q) && !fgt(zlo_q, tmax_q);
  end

  assign hit_o = hit_q;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rbst_pkg::*;

  localparam logic [31:0] F_PZERO   = 32'h0000_0000;
  localparam logic [31:0] F_NZERO   = 32'h8000_0000;
  localparam logic [31:0] F_ONE     = 32'h3F80_0000;
  localparam logic [31:0] F_NONE    = 32'hBF80_0000;
  localparam logic [31:0] F_TWO     = 32'h4000_0000;
  localparam logic [31:0] F_NTHREE  = 32'hC040_0000;
  localparam logic [31:0] F_THREE   = 32'h4040_0000;
  localparam logic [31:0] F_PINF    = 32'h7F80_0000;
  localparam logic [31:0] F_NINF    = 32'hFF80_0000;
  localparam logic [31:0] F_MAX     = 32'h7F7F_FFFF;
  localparam logic [31:0] F_NMAX    = 32'hFF7F_FFFF;
  localparam logic [31:0] F_SUBMIN  = 32'h0000_0001;
  localparam logic [31:0] F_ALLONES = 32'hFFFF_FFFF;
  localparam int          LONG_HOLD = 80;
  localparam int          IDLE_LIMIT = 3000;

  typedef struct packed {
    logic [31:0] ox;
    logic [31:0] oy;
    logic [31:0] oz;
    logic [31:0] dx;
    logic [31:0] dy;
    logic [31:0] dz;
  } ray_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [31:0]          cfg_data;

  rbst_ray_if ray_ch ();
  rbst_hit_if hit_ch ();

  ray_box_slab_test_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ray_i      (ray_ch),
    .hit_o      (hit_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  ray_t        rays_pending[$];
  logic        hits_due[$];
  logic [31:0] box_a[3];
  logic [31:0] box_b[3];
  int          err_cnt = 0;
  bit          quiet = 1'b0;
  int          long_holds_wanted = 0;
  int          long_holds_done = 0;

  // ---------------- single-precision arithmetic helpers ----------------

  function automatic real to_double(logic [31:0] b);
    logic [63:0] d;
    int          p;
    p = 0;
    if (b[30:23] == 8'hFF) begin
      d = (b[22:0] != 0) ? 64'h7FF8_0000_0000_0000 : {b[31], 11'h7FF, 52'd0};
    end else if (b[30:23] == 8'd0) begin
      if (b[22:0] == 0) begin
        d = {b[31], 63'd0};
      end else begin
        for (int i = 0; i < 23; i++) if (b[i]) p = i;
        d = {b[31], 11'(p - 149 + 1023), 52'(64'(b[22:0]) << (52 - p))};
      end
    end else begin
      d = {b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'd0};
    end
    return $bitstoreal(d);
  endfunction

  // Round a double to single with round-to-nearest-even, subnormals included.
  // Doubles hold enough bits that this gives the correctly rounded single result
  // of one add or divide of two singles.
  function automatic logic [31:0] to_single(real r);
    logic [63:0] d;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [32:0] v;
    int          e;
    int          sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? QNAN_BITS : {d[63], 8'hFF, 23'd0};
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    e = int'(d[62:52]) - 1023 + 127;
    if (e >= 255) return {d[63], 8'hFF, 23'd0};
    m  = {11'd0, 1'b1, d[51:0]};
    sh = (e >= 1) ? 29 : 30 - e;
    if (sh > 60) return {d[63], 31'd0};
    q    = m >> sh;
    rem  = m & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    if (e < 1) e = 1;
    v = (33'(e - 1) << 23) + 33'(q);
    if (v >= 33'h7F80_0000) return {d[63], 8'hFF, 23'd0};
    return {d[63], v[30:0]};
  endfunction

  function automatic bit f_nan(logic [31:0] v);
    return v[30:23] == 8'hFF && v[22:0] != 0;
  endfunction

  // Ordered a > b; false with a NaN, and the two zeros are equal.
  function automatic bit f_gt(logic [31:0] a, logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    if (f_nan(a) || f_nan(b)) return 1'b0;
    if (a[30:0] == 0 && b[30:0] == 0) return 1'b0;
    ka = a[31] ? ~a : (a | 32'h8000_0000);
    kb = b[31] ? ~b : (b | 32'h8000_0000);
    return ka > kb;
  endfunction

  function automatic logic [31:0] f_quot(logic [31:0] n, logic [31:0] d);
    if (d[30:0] == 0) begin
      if (f_nan(n) || n[30:0] == 0) return QNAN_BITS;
      return {n[31] ^ d[31], 8'hFF, 23'd0};
    end
    return to_single(to_double(n) / to_double(d));
  endfunction

  task automatic slab_span(input logic [31:0] ca, input logic [31:0] cb,
                           input logic [31:0] o, input logic [31:0] d,
                           output logic [31:0] lo, output logic [31:0] hi);
    logic [31:0] t0;
    logic [31:0] t1;
    t0 = f_quot(to_single(to_double(ca) - to_double(o)), d);
    t1 = f_quot(to_single(to_double(cb) - to_double(o)), d);
    if (f_gt(t0, t1)) begin
      lo = t1;
      hi = t0;
    end else begin
      lo = t0;
      hi = t1;
    end
  endtask

  task automatic predict_hit(input ray_t r, output logic hit);
    logic [31:0] tmin, tmax, ylo, yhi, zlo, zhi;
    slab_span(box_a[0], box_b[0], r.ox, r.dx, tmin, tmax);
    slab_span(box_a[1], box_b[1], r.oy, r.dy, ylo, yhi);
    hit = 1'b1;
    if (f_gt(tmin, yhi) || f_gt(ylo, tmax)) begin
      hit = 1'b0;
    end else begin
      if (f_gt(ylo, tmin)) tmin = ylo;
      if (f_gt(tmax, yhi)) tmax = yhi;
      slab_span(box_a[2], box_b[2], r.oz, r.dz, zlo, zhi);
      if (f_gt(tmin, zhi) || f_gt(zlo, tmax)) hit = 1'b0;
    end
  endtask

  // ---------------- driver ----------------

  int ray_gap;

  always @(posedge clk_i or negedge rst_ni) begin
    ray_t acc;
    logic h;
    if (!rst_ni) begin
      ray_ch.valid <= 1'b0;
      ray_gap      <= 0;
    end else begin
      if (ray_ch.valid && ray_ch.ready) begin
        acc = '{ray_ch.origin_x, ray_ch.origin_y, ray_ch.origin_z,
                ray_ch.dir_x, ray_ch.dir_y, ray_ch.dir_z};
        predict_hit(acc, h);
        hits_due.push_back(h);
      end
      if (!ray_ch.valid || ray_ch.ready) begin
        if (ray_gap > 0) begin
          ray_gap      <= ray_gap - 1;
          ray_ch.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          ray_gap      <= $urandom_range(0, 3);
          ray_ch.valid <= 1'b0;
        end else if (rays_pending.size() > 0) begin
          acc = rays_pending.pop_front();
          ray_ch.valid    <= 1'b1;
          ray_ch.origin_x <= acc.ox;
          ray_ch.origin_y <= acc.oy;
          ray_ch.origin_z <= acc.oz;
          ray_ch.dir_x    <= acc.dx;
          ray_ch.dir_y    <= acc.dy;
          ray_ch.dir_z    <= acc.dz;
        end else begin
          ray_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------

  int hold_left;

  always @(posedge clk_i or negedge rst_ni) begin
    logic want;
    if (!rst_ni) begin
      hit_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else begin
      if (hit_ch.valid && hit_ch.ready) begin
        if (hits_due.size() == 0) begin
          $display("%0t: unexpected hit transfer, expected none actual %0b",
                   $time, hit_ch.hit);
          err_cnt++;
        end else begin
          want = hits_due.pop_front();
          if (hit_ch.hit !== want) begin
            $display("%0t: hit mismatch, expected %0b actual %0b", $time, want, hit_ch.hit);
            err_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        hit_ch.ready <= 1'b0;
      end else if (long_holds_done < long_holds_wanted) begin
        long_holds_done++;
        hold_left    <= LONG_HOLD;
        hit_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold_left    <= $urandom_range(0, 3);
        hit_ch.ready <= 1'b0;
      end else begin
        hit_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------- watchdog ----------------

  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((ray_ch.valid && ray_ch.ready) || (hit_ch.valid && hit_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------- stimulus ----------------

  task automatic add_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                         logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    rays_pending.push_back('{ox, oy, oz, dx, dy, dz});
  endtask

  task automatic write_corner(cfg_reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx == CFG_A_X || idx == CFG_A_Y || idx == CFG_A_Z) box_a[int'(idx)] = val;
    else box_b[int'(idx) - 3] = val;
  endtask

  task automatic set_box(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                         logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
    write_corner(CFG_A_X, ax);
    write_corner(CFG_A_Y, ay);
    write_corner(CFG_A_Z, az);
    write_corner(CFG_B_X, bx);
    write_corner(CFG_B_Y, by);
    write_corner(CFG_B_Z, bz);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    do @(posedge clk_i);
    while (rays_pending.size() != 0 || ray_ch.valid || hits_due.size() != 0);
    repeat (PIPE_LAT + 4) @(posedge clk_i);
  endtask

  function automatic real moderate();
    return (real'($urandom_range(0, 16000)) - 8000.0) / 1000.0;
  endfunction

  function automatic logic [31:0] odd_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 19))
      0: return F_PZERO;
      1: return F_NZERO;
      2: return F_PINF;
      3: return F_NINF;
      4: return {r[31], 8'hFF, r[22:1], 1'b1};
      5: return {r[31], 8'd0, r[22:0]};
      6: return {r[31], F_MAX[30:0]};
      7, 8, 9: return r;
      default: return to_single(moderate());
    endcase
  endfunction

  task automatic random_box();
    logic [31:0] ca[3];
    logic [31:0] cb[3];
    for (int i = 0; i < 3; i++) begin
      ca[i] = ($urandom_range(0, 5) == 0) ? odd_value() : to_single(moderate());
      cb[i] = ($urandom_range(0, 7) == 0) ? ca[i]
            : ($urandom_range(0, 5) == 0) ? odd_value() : to_single(moderate());
    end
    set_box(ca[0], ca[1], ca[2], cb[0], cb[1], cb[2]);
  endtask

  // Mostly rays aimed at a point inside the box, so the later compare stages
  // see real work; the rest is raw and special-valued noise.
  task automatic random_rays(int n);
    logic [31:0] o[3];
    logic [31:0] d[3];
    real         tgt;
    real         fr;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 7) begin
        for (int i = 0; i < 3; i++) begin
          o[i] = to_single(moderate() * 2.0);
          fr   = real'($urandom_range(0, 1000)) / 1000.0;
          if (box_a[i][30:23] == 8'hFF || box_b[i][30:23] == 8'hFF)
            tgt = moderate();
          else
            tgt = to_double(box_a[i]) + fr * (to_double(box_b[i]) - to_double(box_a[i]));
          d[i] = to_single((tgt - to_double(o[i])) * (0.25 + fr));
          if ($urandom_range(0, 9) == 0) d[i] = odd_value();
        end
        if ($urandom_range(0, 9) == 0) o[$urandom_range(0, 2)] = odd_value();
      end else begin
        for (int i = 0; i < 3; i++) begin
          o[i] = odd_value();
          d[i] = odd_value();
        end
      end
      add_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_A_X;
    cfg_data        = '0;
    ray_ch.valid    = 1'b0;
    ray_ch.origin_x = '0;
    ray_ch.origin_y = '0;
    ray_ch.origin_z = '0;
    ray_ch.dir_x    = '0;
    ray_ch.dir_y    = '0;
    ray_ch.dir_z    = '0;
    hit_ch.ready    = 1'b0;
    for (int i = 0; i < 3; i++) begin
      box_a[i] = '0;
      box_b[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Box left at its reset value: a single point at the origin.
    add_ray(F_PZERO, F_PZERO, F_PZERO, F_ONE, F_ONE, F_ONE);
    add_ray(F_ONE, F_PZERO, F_PZERO, F_ONE, F_ONE, F_ONE);
    add_ray(F_PZERO, F_PZERO, F_PZERO, F_PZERO, F_NZERO, F_PZERO);
    drain();

    // Unit box with the corners swapped on two axes.
    set_box(F_ONE, F_NONE, F_ONE, F_NONE, F_ONE, F_NONE);
    add_ray(F_NTHREE, F_PZERO, F_PZERO, F_ONE, F_PZERO, F_PZERO);
    add_ray(F_NTHREE, F_PZERO, F_PZERO, F_ONE, F_NZERO, F_NZERO);
    add_ray(F_NTHREE, F_TWO, F_PZERO, F_ONE, F_PZERO, F_PZERO);
    add_ray(F_THREE, F_PZERO, F_PZERO, F_ONE, F_PZERO, F_PZERO);
    add_ray(F_ONE, F_PZERO, F_PZERO, F_PZERO, F_ONE, F_PZERO);
    add_ray(F_NTHREE, F_NTHREE, F_NTHREE, F_ONE, F_ONE, F_ONE);
    add_ray(F_NTHREE, F_NTHREE, F_NTHREE, F_ONE, F_TWO, F_NTHREE);
    add_ray(QNAN_BITS, F_PZERO, F_PZERO, F_ONE, F_ONE, F_ONE);
    add_ray(F_PINF, F_PZERO, F_PZERO, F_ONE, F_ONE, F_ONE);
    add_ray(F_NTHREE, F_PZERO, F_PZERO, F_ONE, F_ALLONES, F_ONE);
    add_ray(F_NTHREE, F_PZERO, F_PZERO, F_SUBMIN, F_PZERO, F_PZERO);
    add_ray(F_NMAX, F_PZERO, F_PZERO, F_MAX, F_PINF, F_NINF);
    add_ray(F_PZERO, F_PZERO, F_TWO, F_PZERO, F_PZERO, F_PZERO);
    add_ray(F_ALLONES, F_ALLONES, F_ALLONES, F_ALLONES, F_ALLONES, F_ALLONES);
    drain();

    // Extreme corners: a subtraction that overflows and a flat slab.
    set_box(F_MAX, F_NINF, F_SUBMIN, F_NMAX, F_PINF, F_NZERO);
    add_ray(F_NMAX, F_PZERO, F_PZERO, F_ONE, F_ONE, F_ONE);
    add_ray(F_PZERO, F_PZERO, F_NONE, F_ONE, F_ONE, F_ONE);
    add_ray(F_MAX, F_MAX, F_PZERO, F_SUBMIN, F_NZERO, F_SUBMIN);
    add_ray(F_PZERO, F_PZERO, F_PZERO, F_PZERO, F_PZERO, F_PZERO);
    random_rays(30);
    // The sender keeps offering while the receiver holds off, filling the pipe.
    long_holds_wanted++;
    random_rays(30);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      random_box();
      random_rays(80);
      drain();
    end

    quiet = 1'b1;
    random_box();
    random_rays(40);
    drain();

    if (hits_due.size() != 0) begin
      $display("%0t: results missing, expected %0d actual 0", $time, hits_due.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
